>>> hdl/idrr_pkg.sv
// ----------------------------------------------------------------------------
// idrr_pkg
// types, constants and helpers shared by the round-robin interrupt dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package idrr_pkg;

  localparam int unsigned CpuLines = 8;
  localparam int unsigned NumSrc   = 32;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned NumW     = 6;
  localparam int unsigned NumSlots = 6;
  localparam int unsigned SlotW    = 3;

  localparam logic [IdxW-1:0] PtrMask = 5'h1f;
  localparam logic [2:0]      LineReplaced = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_SCAN
  } state_e;

  // sequencer to scan unit
  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } scan_cmd_t;

  // scan unit to sequencer
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] idx;
  } scan_sts_t;

  // dispatch order 7, 2, 3, 4, 5, 6
  function automatic logic [2:0] slot_line(input logic [SlotW-1:0] k);
    logic [2:0] line;
    unique case (k)
      3'd0:    line = 3'd7;
      3'd1:    line = 3'd2;
      3'd2:    line = 3'd3;
      3'd3:    line = 3'd4;
      3'd4:    line = 3'd5;
      3'd5:    line = 3'd6;
      default: line = 3'd0;
    endcase
    return line;
  endfunction

  // active bits rearranged into dispatch order
  function automatic logic [NumSlots-1:0] slot_mask(input logic [CpuLines-1:0] active);
    logic [NumSlots-1:0] m;
    for (int k = 0; k < NumSlots; k++) begin
      m[k] = active[slot_line(SlotW'(k))];
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hdl/idrr_if.sv
// ----------------------------------------------------------------------------
// idrr_in_if / idrr_out_if
// valid/ready channels for dispatch requests and dispatch results
// ----------------------------------------------------------------------------
`default_nettype none

interface idrr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cpu_pending;
  logic [7:0]  cpu_enable;
  logic [31:0] internal_pending;

  modport source (output valid, cpu_pending, cpu_enable, internal_pending, input ready);
  modport sink   (input valid, cpu_pending, cpu_enable, internal_pending, output ready);
endinterface

interface idrr_out_if;
  logic       valid;
  logic       ready;
  logic       grant_valid;
  logic [5:0] irq_number;
  logic [7:0] enable_clear;
  logic       last;

  modport source (output valid, grant_valid, irq_number, enable_clear, last, input ready);
  modport sink   (input valid, grant_valid, irq_number, enable_clear, last, output ready);
endinterface

`default_nettype wire

>>> hdl/idrr_scan.sv
// ----------------------------------------------------------------------------
// idrr_scan
// round-robin search over the internal pending snapshot, one index a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module idrr_scan
  import idrr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire scan_cmd_t         cmd_i,
  input  wire logic [NumSrc-1:0] ipend_i,
  output scan_sts_t              sts_o
);

  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] idx_inc;

  assign idx_inc = (idx_q + IdxW'(1)) & PtrMask;

  always_comb begin
    ptr_d = ptr_q;
    idx_d = idx_q;
    if (cmd_i.start) begin
      idx_d = ptr_q;
    end else if (cmd_i.step) begin
      idx_d = idx_inc;
    end
    if (cmd_i.commit) begin
      ptr_d = idx_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  assign sts_o.hit = ipend_i[idx_q];
  assign sts_o.idx = idx_q;

endmodule

`default_nettype wire

>>> hdl/interrupt_dispatch_round_robin.sv
// ----------------------------------------------------------------------------
// interrupt_dispatch_round_robin
// dispatches active cpu lines in order 7,2,3,4,5,6; line 3 is replaced by a
// round-robin pick among the internal controller sources
// ----------------------------------------------------------------------------
//
//  channel     dir  modport  word
//  dispatch_i  in   sink     cpu_pending, cpu_enable, internal_pending
//  result_o    out  source   grant_valid, irq_number, enable_clear, last
//
// one request word yields one to six result words, the last one flagged
// a request is taken only when the sequencer is idle; then the sequencer walks
//   the dispatch slots up to the last active one (six slots), with a scan of
//   the internal sources when line 3 is active with internal bits pending
// the scan unit examines one internal index a cycle from the rr pointer
// a stalled result register holds the sequencer in place, no word is dropped
// reset clears the sequencer, the output valid and the rr pointer
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_dispatch_round_robin
  import idrr_pkg::*;
#(
  parameter int unsigned INTERNAL_BASE = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  idrr_in_if.sink     dispatch_i,
  idrr_out_if.source  result_o
);

  // internal numbers wrap at the 6-bit field width
  localparam logic [NumW-1:0] BaseMod = NumW'(INTERNAL_BASE % 64);

  // sequencer state
  state_e               state_q, state_d;
  logic [SlotW-1:0]     k_q, k_d;
  logic [CpuLines-1:0]  active_q, active_d;
  logic [NumSlots-1:0]  sm_q, sm_d;
  logic [NumSrc-1:0]    ipend_q, ipend_d;

  // result register
  logic                 ovalid_q, ovalid_d;
  logic                 ogv_q, ogv_d;
  logic [NumW-1:0]      onum_q, onum_d;
  logic [CpuLines-1:0]  oclr_q, oclr_d;
  logic                 olast_q, olast_d;

  scan_cmd_t            scan_cmd;
  scan_sts_t            scan_sts;

  logic                 in_fire;
  logic                 out_free;
  logic [2:0]           cur_line;
  logic                 is_last;
  logic                 load;

  // ready is high exactly in idle
  assign in_fire  = dispatch_i.valid && (state_q == ST_IDLE);
  // result register can take a new word this cycle
  assign out_free = !ovalid_q || result_o.ready;
  assign cur_line = slot_line(k_q);
  // no active slot after the current one
  assign is_last  = ((sm_q >> k_q) >> 1) == '0;

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    active_d = active_q;
    sm_d     = sm_q;
    ipend_d  = ipend_q;
    ogv_d    = ogv_q;
    onum_d   = onum_q;
    oclr_d   = oclr_q;
    olast_d  = olast_q;
    load     = 1'b0;
    scan_cmd = '0;
    dispatch_i.ready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        dispatch_i.ready = 1'b1;
        if (in_fire) begin
          active_d = dispatch_i.cpu_pending & dispatch_i.cpu_enable;
          sm_d     = slot_mask(active_d);
          ipend_d  = dispatch_i.internal_pending;
          k_d      = '0;
          state_d  = ST_SLOT;
        end
      end
      ST_SLOT: begin
        if (sm_q == '0) begin
          // nothing to dispatch: single no-grant word
          if (out_free) begin
            load    = 1'b1;
            ogv_d   = 1'b0;
            onum_d  = '0;
            oclr_d  = active_q;
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (!sm_q[k_q]) begin
          k_d = k_q + SlotW'(1);
        end else if (cur_line == LineReplaced && ipend_q != '0) begin
          // line 3 gives way to an internal source
          scan_cmd.start = 1'b1;
          state_d        = ST_SCAN;
        end else if (out_free) begin
          load    = 1'b1;
          ogv_d   = 1'b1;
          onum_d  = NumW'(cur_line);
          oclr_d  = active_q;
          olast_d = is_last;
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d = k_q + SlotW'(1);
          end
        end
      end
      ST_SCAN: begin
        if (!scan_sts.hit) begin
          scan_cmd.step = 1'b1;
        end else if (out_free) begin
          load            = 1'b1;
          scan_cmd.commit = 1'b1;
          ogv_d           = 1'b1;
          onum_d          = BaseMod + NumW'(scan_sts.idx);
          oclr_d          = active_q;
          olast_d         = is_last;
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + SlotW'(1);
            state_d = ST_SLOT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // valid drops once the word is taken unless a new one is loaded
    if (load) begin
      ovalid_d = 1'b1;
    end else if (result_o.ready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    active_q <= active_d;
    sm_q     <= sm_d;
    ipend_q  <= ipend_d;
    ogv_q    <= ogv_d;
    onum_q   <= onum_d;
    oclr_q   <= oclr_d;
    olast_q  <= olast_d;
  end

  // round-robin scan unit for the internal sources
  idrr_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (scan_cmd),
    .ipend_i (ipend_q),
    .sts_o   (scan_sts)
  );

  assign result_o.valid        = ovalid_q;
  assign result_o.grant_valid  = ogv_q;
  assign result_o.irq_number   = onum_q;
  assign result_o.enable_clear = oclr_q;
  assign result_o.last         = olast_q;

endmodule

`default_nettype wire

>>> hdl/idrr_checker.sv
// ----------------------------------------------------------------------------
// idrr_checker
// port-level checks for the round-robin interrupt dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

module idrr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_grant_valid,
  input wire logic [5:0] out_irq_number,
  input wire logic [7:0] out_enable_clear,
  input wire logic       out_last
);

  // a stalled result word holds its number, last flag and grant flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_irq_number)
      && $stable(out_last) && $stable(out_grant_valid))
    else $error("result word changed while stalled");

  // block is busy right after taking a request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // no-grant word is a lone final word with number zero
  a_nogrant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_grant_valid |-> out_last && out_irq_number == 6'd0)
    else $error("malformed no-grant word");

  // no-grant only when lines 2..7 are all inactive
  a_nogrant_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_grant_valid |-> out_enable_clear[7:2] == 6'd0)
    else $error("no-grant with active dispatchable line");

endmodule

bind interrupt_dispatch_round_robin idrr_checker u_idrr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid         (dispatch_i.valid),
  .in_ready         (dispatch_i.ready),
  .out_valid        (result_o.valid),
  .out_ready        (result_o.ready),
  .out_grant_valid  (result_o.grant_valid),
  .out_irq_number   (result_o.irq_number),
  .out_enable_clear (result_o.enable_clear),
  .out_last         (result_o.last)
);

`default_nettype wire

>>> tb/sv/interrupt_dispatch_round_robin_test.sv
// ----------------------------------------------------------------------------
// interrupt_dispatch_round_robin_test
// Self-checking bench for the round-robin interrupt dispatcher. A behavioral
// model of the dispatch order and the internal rr pointer predicts the
// result words of every accepted request word. A checker compares each
// result word, field by field, with the oldest prediction. Both channels
// idle at random. Directed corner requests come first, then random traffic
// and round-robin sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_dispatch_round_robin_test;
  import idrr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IntBase    = 8;
  localparam int unsigned CycleLimit = 1_000_000;
  // worst case request: six slots plus a full 32-index scan
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned ReportCap  = 50;

  // fixed dispatch order of the cpu lines
  localparam logic [2:0] DispatchOrder [NumSlots] = '{3'd7, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};

  typedef struct packed {
    logic            grant_valid;
    logic [NumW-1:0] irq_number;
    logic [7:0]      enable_clear;
    logic            last;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  idrr_in_if  dispatch_if ();
  idrr_out_if result_if ();

  interrupt_dispatch_round_robin #(
    .INTERNAL_BASE(IntBase)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .dispatch_i(dispatch_if),
    .result_o  (result_if)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predicted result words, oldest first, and the model's rr pointer
  grant_t          pending_grants[$];
  logic [IdxW-1:0] rr_next_idx;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // idling switches for the sender and the receiver
  bit          src_idle = 1'b0;
  bit          sink_idle = 1'b0;
  int unsigned sink_hold = 0;

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // internal pending snapshot: empty, one bit, a few bits, full or random
  function automatic logic [31:0] rand_internal();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1:    v = '0;
      2, 3:    v = 32'h1 << $urandom_range(0, 31);
      4, 5:    v = (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, 31))
                   | (32'h1 << $urandom_range(0, 31));
      6:       v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < ReportCap) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // behavioral model of one dispatch request: push its result words
  task automatic predict_dispatch(input logic [7:0] pend, input logic [7:0] en,
                                  input logic [31:0] ipend);
    logic [7:0]      active;
    logic [IdxW-1:0] idx;
    logic [2:0]      line;
    grant_t          g;
    grant_t          words[$];
    active = pend & en;
    for (int k = 0; k < NumSlots; k++) begin
      line = DispatchOrder[k];
      if (active[line]) begin
        g.grant_valid  = 1'b1;
        g.enable_clear = active;
        g.last         = 1'b0;
        if (line == LineReplaced && ipend != '0) begin
          // upward scan with wrap from the rr pointer, 5-bit index wraps itself
          idx = rr_next_idx;
          for (int s = 0; s < NumSrc; s++) begin
            if (ipend[idx]) break;
            idx++;
          end
          rr_next_idx  = idx + 1'b1;
          g.irq_number = NumW'(IntBase + int'(idx));
        end else begin
          g.irq_number = NumW'(line);
        end
        words.push_back(g);
      end
    end
    if (words.size() == 0) begin
      // nothing among lines 2..7: a single no-grant word
      g.grant_valid  = 1'b0;
      g.irq_number   = '0;
      g.enable_clear = active;
      g.last         = 1'b1;
      words.push_back(g);
    end
    words[words.size()-1].last = 1'b1;
    foreach (words[i]) pending_grants.push_back(words[i]);
  endtask

  // drive one request word at the falling edge, hold it until taken
  task automatic send_dispatch(input logic [7:0] pend, input logic [7:0] en,
                               input logic [31:0] ipend);
    int unsigned gap;
    @(negedge clk_i);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      gap = idle_len();
      dispatch_if.valid            = 1'b0;
      // junk on the payload while idle
      dispatch_if.cpu_pending      = 8'($urandom);
      dispatch_if.cpu_enable       = 8'($urandom);
      dispatch_if.internal_pending = $urandom;
      repeat (gap) @(negedge clk_i);
    end
    dispatch_if.valid            = 1'b1;
    dispatch_if.cpu_pending      = pend;
    dispatch_if.cpu_enable       = en;
    dispatch_if.internal_pending = ipend;
    @(posedge clk_i);
    while (!dispatch_if.ready) @(posedge clk_i);
    predict_dispatch(pend, en, ipend);
  endtask

  // sender holds off until every predicted word has come out
  task automatic drain_results();
    @(negedge clk_i);
    dispatch_if.valid = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // corner requests, no idling
  task automatic test_directed();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    // nothing pending, pending without enable, enable without pending
    send_dispatch(8'h00, 8'h00, 32'h0000_0000);
    send_dispatch(8'hff, 8'h00, 32'hffff_ffff);
    send_dispatch(8'h00, 8'hff, 32'hffff_ffff);
    // lines 0 and 1 only clear enables, never dispatch
    send_dispatch(8'h03, 8'h03, 32'hffff_ffff);
    // every dispatchable line alone, line 3 reports itself without internal bits
    for (int l = 2; l < CpuLines; l++) send_dispatch(8'h01 << l, 8'hff, 32'h0);
    // top internal index, pointer wraps to zero
    send_dispatch(8'h08, 8'h08, 32'h8000_0000);
    send_dispatch(8'h08, 8'h08, 32'h0000_0001);
    // scan wraps past index 31 back to 0
    send_dispatch(8'h08, 8'h08, 32'h0000_0001);
    // line 3 inactive: internal bits ignored, pointer kept
    send_dispatch(8'h04, 8'h04, 32'hffff_ffff);
    // all six slots, line 3 replaced
    send_dispatch(8'hff, 8'hff, 32'hffff_ffff);
    send_dispatch(8'hff, 8'hff, 32'hffff_ffff);
    // all six slots, line 3 itself, then replaced with alternating internal bits
    send_dispatch(8'hfc, 8'hfc, 32'h0);
    send_dispatch(8'hff, 8'hff, 32'haaaa_aaaa);
    send_dispatch(8'hff, 8'hff, 32'h5555_5555);
    drain_results();
  endtask

  // random requests in chunks with varying idling
  task automatic test_random_mix();
    logic [7:0] pend;
    logic [7:0] en;
    for (int chunk = 0; chunk < 6; chunk++) begin
      src_idle  = $urandom_range(0, 2) != 0;
      sink_idle = $urandom_range(0, 2) != 0;
      for (int i = 0; i < 37; i++) begin
        pend = 8'($urandom);
        en   = ($urandom_range(0, 1) == 0) ? 8'hff : 8'($urandom);
        send_dispatch(pend, en, rand_internal());
      end
      if (chunk == 2) drain_results();
    end
  endtask

  // line 3 mostly active with varied internal bits to walk the rr pointer
  task automatic test_round_robin();
    logic [7:0] pend;
    logic [7:0] en;
    for (int chunk = 0; chunk < 5; chunk++) begin
      src_idle  = chunk != 0;
      sink_idle = chunk > 1;
      for (int i = 0; i < 44; i++) begin
        if ($urandom_range(0, 99) < 15) begin
          // noise
          send_dispatch(8'($urandom), 8'($urandom), $urandom);
        end else begin
          pend = 8'h08 | (($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
          en   = 8'h08 | 8'($urandom);
          send_dispatch(pend, en, rand_internal());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls on the result channel
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      result_if.ready = 1'b0;
      sink_hold--;
    end else if (sink_idle && $urandom_range(0, 5) == 0) begin
      result_if.ready = 1'b0;
      sink_hold = idle_len() - 1;
    end else begin
      result_if.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every taken result word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected word gv=%0b num=%0d clr=%02h last=%0b",
                        result_if.grant_valid, result_if.irq_number,
                        result_if.enable_clear, result_if.last));
      end else begin
        want = pending_grants.pop_front();
        if (result_if.grant_valid !== want.grant_valid ||
            result_if.irq_number !== want.irq_number ||
            result_if.enable_clear !== want.enable_clear ||
            result_if.last !== want.last) begin
          report_mismatch($sformatf(
            "got gv=%0b num=%0d clr=%02h last=%0b, want gv=%0b num=%0d clr=%02h last=%0b",
            result_if.grant_valid, result_if.irq_number, result_if.enable_clear,
            result_if.last, want.grant_valid, want.irq_number, want.enable_clear,
            want.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_grants.size());
      $display("FAIL interrupt_dispatch_round_robin");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni                       = 1'b0;
    rr_next_idx                  = '0;
    dispatch_if.valid            = 1'b0;
    dispatch_if.cpu_pending      = '0;
    dispatch_if.cpu_enable       = '0;
    dispatch_if.internal_pending = '0;
    result_if.ready              = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_mix();
    test_round_robin();

    // let the last request finish, then a quiet spell for stray words
    @(negedge clk_i);
    dispatch_if.valid = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS interrupt_dispatch_round_robin");
    end else begin
      $display("FAIL interrupt_dispatch_round_robin");
    end
    $finish;
  end

endmodule

`default_nettype wire
